// ===== rtl/pidf_pkg.sv =====
// ----------------------------------------------------------------------------
// pidf_pkg: shared types and constants of the filtered-derivative PID core
// Data types, register indexes, request codes, filter weights and the
// signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pidf_pkg;

	localparam int DATA_W    = 32;
	localparam int DT_FRAC_W = 24;

	typedef logic signed [DATA_W-1:0] sdata_t;
	typedef logic        [DATA_W-1:0] udata_t;
	typedef logic        [2:0]        cfg_idx_t;

	localparam cfg_idx_t CFG_PROP_GAIN  = 3'd0;
	localparam cfg_idx_t CFG_INTEG_GAIN = 3'd1;
	localparam cfg_idx_t CFG_DERIV_GAIN = 3'd2;
	localparam cfg_idx_t CFG_LIMIT_HIGH = 3'd3;
	localparam cfg_idx_t CFG_LIMIT_LOW  = 3'd4;
	localparam cfg_idx_t CFG_RUN_ENABLE = 3'd5;

	localparam logic REQ_COMPUTE = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;

	localparam sdata_t LIMIT_HIGH_RST = 32'sd65536;
	localparam sdata_t LIMIT_LOW_RST  = -32'sd65536;

	// Q0.16 smoothing weights, 0.9 and 0.1, summing to exactly one
	localparam logic signed [DATA_W:0] SMOOTH_OLD_W = 33'sd58982;
	localparam logic signed [DATA_W:0] SMOOTH_NEW_W = 33'sd6554;

	function automatic sdata_t sat32(input logic signed [63:0] v);
		sdata_t r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pidf_if.sv =====
// ----------------------------------------------------------------------------
// pidf_if: request and response channels of the PID core
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidf_req_if;
	import pidf_pkg::*;

	logic   valid;
	logic   ready;
	logic   req_type;
	sdata_t target;
	sdata_t measured;
	udata_t step_time;

	modport source (output valid, req_type, target, measured, step_time, input ready);
	modport sink   (input valid, req_type, target, measured, step_time, output ready);
endinterface

interface pidf_rsp_if;
	import pidf_pkg::*;

	logic   valid;
	logic   ready;
	sdata_t drive;

	modport source (output valid, drive, input ready);
	modport sink   (input valid, drive, output ready);
endinterface

`default_nettype wire

// ===== rtl/pidf_div.sv =====
// ----------------------------------------------------------------------------
// pidf_div: bit-serial signed divider for the raw derivative
// Computes sat32((dividend << 24) / divisor), truncated toward zero, one
// quotient bit per cycle by restoring division on the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module pidf_div (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  pidf_pkg::sdata_t dividend,
	input  pidf_pkg::udata_t divisor,
	output logic            busy,
	output logic            done,
	output pidf_pkg::sdata_t quotient
);
	import pidf_pkg::*;

	localparam int NUM_W = DATA_W + DT_FRAC_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	udata_t             rem_q;
	udata_t             dvs_q;
	logic [NUM_W-1:0]   quo_q;

	udata_t             mag;
	logic [DATA_W:0]    rem_sh;
	logic [DATA_W:0]    rem_nx;
	logic               ge;

	assign mag    = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= dividend[DATA_W-1];
				dvs_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= {mag, {DT_FRAC_W{1'b0}}};
			end else if (busy_q) begin
				quo_q <= {quo_q[NUM_W-2:0], ge};
				rem_q <= rem_nx[DATA_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// apply the sign and saturate the magnitude to the signed 32-bit range
	always_comb begin
		if (!neg_q) begin
			if (|quo_q[NUM_W-1:DATA_W-1]) begin
				quotient = 32'sh7FFF_FFFF;
			end else begin
				quotient = quo_q[DATA_W-1:0];
			end
		end else begin
			if ((|quo_q[NUM_W-1:DATA_W]) ||
			    (quo_q[DATA_W-1] && (|quo_q[DATA_W-2:0]))) begin
				quotient = 32'sh8000_0000;
			end else begin
				quotient = ~quo_q[DATA_W-1:0] + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/pid_controller_filtered_derivative_core.sv =====
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative_core: PID controller, smoothed derivative
// Signed Q16.16 PID with a clamped integral and a 0.9/0.1 derivative filter.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transaction: compute (target, measured,
//   step_time) or clear. rsp returns one drive value per request, in order.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user must
//   do so only while idle, unchecked by the block. An index above five is ignored.
// Sequencing:
//   A compute request runs the multiplies for the P, I and D terms, then the
//   derivative division, skipped when step_time is zero, and the smoothing
//   filter before rsp valid. A clear request or a compute request while
//   run_enable is low goes straight to the output register. The next request
//   is taken only once the previous result is loaded into the output register.
//   A bit-serial divider resolves the 56 quotient bits, one a cycle.
//   Products go through one shared 33x33 multiplier, one per cycle.
//   One request is worked on at a time; req.ready is high only when idle.
// Reset: gains clear, limits go to +1.0 / -1.0, run_enable is set, and the
//   integral, previous error, last drive and filter state go to zero.
// Stall: a result waits in the output register while rsp.ready is low; the
//   next request may be taken and computed, then waits to load it.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_filtered_derivative_core (
	input  wire              clk,
	input  wire              arst_n,
	pidf_req_if.sink         req,
	pidf_rsp_if.source       rsp,
	input  wire              cfg_we,
	input  pidf_pkg::cfg_idx_t cfg_index,
	input  pidf_pkg::udata_t cfg_data
);
	import pidf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_I,
		S_MUL_INC,
		S_MUL_D,
		S_DIV_START,
		S_DIV,
		S_SMOOTH_A,
		S_SMOOTH_B,
		S_SMOOTH_SUM,
		S_FIN,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	sdata_t kp_q, ki_q, kd_q, lim_hi_q, lim_lo_q;
	logic   run_en_q;

	// controller state
	sdata_t integ_q, last_err_q, last_drive_q, dsmooth_q;

	// per-request working registers
	sdata_t err_q, diff_q, pterm_q, raw_q;
	udata_t dt_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] sum_q;

	// output register
	logic   out_valid_q;
	sdata_t out_drive_q;

	logic signed [DATA_W:0]     mul_a, mul_b;
	logic signed [2*DATA_W+1:0] prod;
	sdata_t sh16, sh24;

	logic   div_start, div_busy, div_done;
	sdata_t div_quo;

	function automatic logic signed [63:0] sx64(input sdata_t v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic sdata_t clamp(input sdata_t v, input sdata_t hi, input sdata_t lo);
		sdata_t r;
		r = v;
		if (r > hi) begin
			r = hi;
		end
		if (r < lo) begin
			r = lo;
		end
		return r;
	endfunction

	assign sh16 = sat32(prod_q >>> 16);
	assign sh24 = sat32(prod_q >>> DT_FRAC_W);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_MUL_P: begin
				mul_a = {kp_q[31], kp_q};
				mul_b = {err_q[31], err_q};
			end
			S_MUL_I: begin
				mul_a = {ki_q[31], ki_q};
				mul_b = {err_q[31], err_q};
			end
			S_MUL_INC: begin
				mul_a = {sh16[31], sh16};
				mul_b = {1'b0, dt_q};
			end
			S_MUL_D: begin
				mul_a = {kd_q[31], kd_q};
				mul_b = {diff_q[31], diff_q};
			end
			S_SMOOTH_A: begin
				mul_a = SMOOTH_OLD_W;
				mul_b = {dsmooth_q[31], dsmooth_q};
			end
			S_SMOOTH_B: begin
				mul_a = SMOOTH_NEW_W;
				mul_b = {raw_q[31], raw_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign div_start = (state_q == S_DIV_START) && (dt_q != '0);

	pidf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sh16),
		.divisor  (dt_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kp_q         <= '0;
			ki_q         <= '0;
			kd_q         <= '0;
			lim_hi_q     <= LIMIT_HIGH_RST;
			lim_lo_q     <= LIMIT_LOW_RST;
			run_en_q     <= 1'b1;
			integ_q      <= '0;
			last_err_q   <= '0;
			last_drive_q <= '0;
			dsmooth_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PROP_GAIN:  kp_q     <= cfg_data;
					CFG_INTEG_GAIN: ki_q     <= cfg_data;
					CFG_DERIV_GAIN: kd_q     <= cfg_data;
					CFG_LIMIT_HIGH: lim_hi_q <= cfg_data;
					CFG_LIMIT_LOW:  lim_lo_q <= cfg_data;
					CFG_RUN_ENABLE: run_en_q <= cfg_data[0];
					default: ;
				endcase
			end

			// in S_EMIT the load below decides the output valid
			if (rsp.valid && rsp.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						dt_q  <= req.step_time;
						err_q <= sat32(sx64(req.target) - sx64(req.measured));
						if (req.req_type == REQ_CLEAR) begin
							integ_q      <= '0;
							last_err_q   <= '0;
							last_drive_q <= '0;
							state_q      <= S_EMIT;
						end else if (!run_en_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MUL_P;
						end
					end
				end
				S_MUL_P: begin
					prod_q  <= prod[63:0];
					diff_q  <= sat32(sx64(err_q) - sx64(last_err_q));
					state_q <= S_MUL_I;
				end
				S_MUL_I: begin
					pterm_q <= sh16;
					prod_q  <= prod[63:0];
					state_q <= S_MUL_INC;
				end
				S_MUL_INC: begin
					prod_q  <= prod[63:0];
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					integ_q <= clamp(sat32(sx64(integ_q) + sx64(sh24)), lim_hi_q, lim_lo_q);
					prod_q  <= prod[63:0];
					state_q <= S_DIV_START;
				end
				S_DIV_START: begin
					// zero step time: no division, raw derivative is zero
					if (dt_q == '0) begin
						raw_q   <= '0;
						state_q <= S_SMOOTH_A;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						raw_q   <= div_quo;
						state_q <= S_SMOOTH_A;
					end
				end
				S_SMOOTH_A: begin
					prod_q  <= prod[63:0];
					state_q <= S_SMOOTH_B;
				end
				S_SMOOTH_B: begin
					sum_q   <= prod_q;
					prod_q  <= prod[63:0];
					state_q <= S_SMOOTH_SUM;
				end
				S_SMOOTH_SUM: begin
					dsmooth_q <= sat32((sum_q + prod_q) >>> 16);
					state_q   <= S_FIN;
				end
				S_FIN: begin
					last_drive_q <= clamp(sat32(sx64(pterm_q) + sx64(integ_q) + sx64(dsmooth_q)),
					                      lim_hi_q, lim_lo_q);
					last_err_q   <= err_q;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_drive_q <= last_drive_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.drive = out_drive_q;

`ifndef NO_ASSERTIONS
	a_drive_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && (lim_lo_q <= lim_hi_q) |=>
		(last_drive_q <= $past(lim_hi_q)) && (last_drive_q >= $past(lim_lo_q)))
		else $error("computed drive outside the output limits");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the wait state");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !div_busy)
		else $error("request accepted while the divider is busy");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_pid_controller_filtered_derivative_core.sv =====
// ----------------------------------------------------------------------------
// tb_pid_controller_filtered_derivative_core: self-checking bench of the PID core
// A directed table of register writes and requests, then random phases of
// settings and tracking, noisy or clear requests, sent in bursts, with a stalling
// response side. Each drive is checked by a cycle-free Q16.16 model or typed row.
// ----------------------------------------------------------------------------
module tb_pid_controller_filtered_derivative_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pidf_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int RANDOM_ITEMS = 1150;
	localparam int TAIL_CYCLES  = 100;
	localparam int REPORT_MAX   = 30;

	localparam longint FILTER_KEEP = 58982;
	localparam longint FILTER_TAKE = 6554;

	localparam cfg_idx_t IDX_NONE   = CFG_PROP_GAIN;
	localparam cfg_idx_t CFG_BAD_LO = 3'd6;
	localparam cfg_idx_t CFG_BAD_HI = 3'd7;

	localparam udata_t Q_MAX  = 32'h7FFFFFFF;
	localparam udata_t Q_MIN  = 32'h80000000;
	localparam udata_t Q_ONE  = 32'h00010000;
	localparam udata_t Q_NEG1 = 32'hFFFF0000;
	localparam udata_t DT_ONE = 32'h01000000;
	localparam udata_t W_ALL  = 32'hFFFFFFFF;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SEND, ROW_CHECK} row_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

	// value is the write data of a register row and the typed drive of a checked row
	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t  index;
		logic      req_type;
		sdata_t    target;
		sdata_t    measured;
		udata_t    step_time;
		udata_t    value;
	} plan_row_t;

	localparam int PLAN_LEN = 37;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, Q_MAX, Q_MIN, W_ALL, 32'h0},
		'{ROW_WRITE, CFG_PROP_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MAX},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, Q_MAX, Q_MIN, 32'h0, Q_ONE},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, Q_MIN, Q_MAX, 32'h0, Q_NEG1},
		'{ROW_WRITE, CFG_LIMIT_HIGH, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MAX},
		'{ROW_WRITE, CFG_LIMIT_LOW, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MIN},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, Q_MAX, Q_MIN, 32'h1, Q_MAX},
		// disabled: hold the last drive, but a clear still zeroes it
		'{ROW_WRITE, CFG_RUN_ENABLE, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, 32'h0},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, Q_ONE, 32'h0, DT_ONE, Q_MAX},
		'{ROW_CHECK, IDX_NONE, REQ_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, Q_ONE, 32'h0, DT_ONE, 32'h0},
		'{ROW_WRITE, CFG_RUN_ENABLE, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, 32'h1},
		'{ROW_WRITE, CFG_PROP_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MIN},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, 32'h1, 32'h0, DT_ONE, 32'hFFFF8000},
		// inverted limits: the lower one wins
		'{ROW_WRITE, CFG_LIMIT_HIGH, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_NEG1},
		'{ROW_WRITE, CFG_LIMIT_LOW, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_ONE},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, 32'h0, 32'h0, DT_ONE, Q_ONE},
		'{ROW_WRITE, CFG_BAD_LO, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MIN},
		'{ROW_WRITE, CFG_BAD_HI, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFE},
		'{ROW_CHECK, IDX_NONE, REQ_COMPUTE, 32'h00050000, 32'h0, DT_ONE, Q_ONE},
		'{ROW_WRITE, CFG_PROP_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_ONE},
		'{ROW_WRITE, CFG_INTEG_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MAX},
		'{ROW_WRITE, CFG_DERIV_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MIN},
		'{ROW_WRITE, CFG_LIMIT_HIGH, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, 32'h00400000},
		'{ROW_WRITE, CFG_LIMIT_LOW, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, 32'hFFC00000},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, 32'h00020000, 32'h00008000, DT_ONE, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, 32'h00020000, 32'h00008000, 32'h0, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, Q_MIN, Q_MAX, W_ALL, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, Q_MAX, Q_MIN, 32'h1, 32'h0},
		// the derivative filter must survive a clear
		'{ROW_SEND, IDX_NONE, REQ_CLEAR, W_ALL, W_ALL, W_ALL, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, Q_ONE, 32'h0, 32'h00100000, 32'h0},
		'{ROW_WRITE, CFG_DERIV_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MAX},
		'{ROW_WRITE, CFG_INTEG_GAIN, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, Q_MIN},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, Q_NEG1, Q_ONE, 32'h00000400, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, 32'h0, 32'h0, 32'h0, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, 32'h12345678, 32'hEDCBA987, Q_MIN, 32'h0},
		'{ROW_SEND, IDX_NONE, REQ_COMPUTE, 32'h00003000, 32'hFFFFD000, DT_ONE, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	udata_t cfg_data;

	pidf_req_if req_ch ();
	pidf_rsp_if rsp_ch ();

	pid_controller_filtered_derivative_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Controller model: registers and state, kept as sign-extended 32-bit values
	longint kp_q, ki_q, kd_q, lim_hi, lim_lo;
	logic   run_on;
	longint integ_q, err_hist, held_drive, smooth_q;

	sdata_t drive_expect_q[$];
	logic   pin_on;
	sdata_t pin_drive;
	sdata_t want_drive;

	int n_fail, n_checked, n_writes, n_compute, n_clear, n_held, n_zero_dt;
	int cycle_count;

	rx_mode_t    rx_mode;
	int unsigned rx_left;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// upper limit first, so inverted limits settle on the lower one
	function automatic longint clamp_drive(longint v);
		if (v > lim_hi) v = lim_hi;
		if (v < lim_lo) v = lim_lo;
		return v;
	endfunction

	function automatic sdata_t pid_next_drive(logic kind, sdata_t tgt, sdata_t meas,
		udata_t dt_q);
		longint err, p_term, ki_err, integ_inc, err_delta, kd_delta, deriv_raw, dt;
		dt = longint'(dt_q);
		if (kind == REQ_CLEAR) begin
			integ_q = 0;
			err_hist = 0;
			held_drive = 0;
		end else if (run_on) begin
			err = sat_s32(longint'(tgt) - longint'(meas));
			p_term = sat_s32((kp_q * err) >>> 16);
			ki_err = sat_s32((ki_q * err) >>> 16);
			integ_inc = sat_s32((ki_err * dt) >>> 24);
			integ_q = clamp_drive(sat_s32(integ_q + integ_inc));
			err_delta = sat_s32(err - err_hist);
			kd_delta = sat_s32((kd_q * err_delta) >>> 16);
			deriv_raw = 0;
			if (dt != 0) deriv_raw = sat_s32((kd_delta * 64'sd16777216) / dt);
			smooth_q = sat_s32((FILTER_KEEP * smooth_q + FILTER_TAKE * deriv_raw) >>> 16);
			held_drive = clamp_drive(sat_s32(p_term + integ_q + smooth_q));
			err_hist = err;
		end
		return sdata_t'(held_drive);
	endfunction

	task automatic report_mismatch(string msg);
		if (n_fail < REPORT_MAX) $display("mismatch @%0t: %s", $realtime, msg);
		n_fail++;
	endtask

	function automatic udata_t pick_word();
		case ($urandom_range(7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 32'h0;
			3: return W_ALL;
			default: return $urandom();
		endcase
	endfunction

	function automatic udata_t pick_gain();
		case ($urandom_range(9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return $urandom();
			3: return 32'h0;
			default: return udata_t'($urandom_range(0, 32'h00200000)) - 32'h00100000;
		endcase
	endfunction

	task automatic write_reg(cfg_idx_t idx, udata_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_PROP_GAIN:  kp_q = longint'($signed(data));
			CFG_INTEG_GAIN: ki_q = longint'($signed(data));
			CFG_DERIV_GAIN: kd_q = longint'($signed(data));
			CFG_LIMIT_HIGH: lim_hi = longint'($signed(data));
			CFG_LIMIT_LOW:  lim_lo = longint'($signed(data));
			CFG_RUN_ENABLE: run_on = data[0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic send_item(logic kind, sdata_t tgt, sdata_t meas, udata_t dt,
		logic pinned, sdata_t typed_drive);
		cfg_we <= 1'b0;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.target <= tgt;
		req_ch.measured <= meas;
		req_ch.step_time <= dt;
		pin_on <= pinned;
		pin_drive <= typed_drive;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// drop valid and hold until every expected drive has come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (drive_expect_q.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.req_type == REQ_CLEAR) n_clear++;
				else if (!run_on) n_held++;
				else if (req_ch.step_time == 0) n_zero_dt++;
				if (req_ch.req_type == REQ_COMPUTE) n_compute++;
				want_drive = pid_next_drive(req_ch.req_type, req_ch.target,
					req_ch.measured, req_ch.step_time);
				drive_expect_q.push_back(pin_on ? pin_drive : want_drive);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (drive_expect_q.size() == 0) begin
					report_mismatch($sformatf("drive %h with no request waiting",
						rsp_ch.drive));
				end else begin
					want_drive = drive_expect_q.pop_front();
					n_checked++;
					if (rsp_ch.drive !== want_drive) begin
						report_mismatch($sformatf("drive %h, expected %h",
							rsp_ch.drive, want_drive));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d drives outstanding", cycle_count,
				drive_expect_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// response side: open, choppy and nearly closed stretches of random length
	initial begin
		rsp_ch.ready = 1'b0;
		rx_left = 0;
		rx_mode = RX_OPEN;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(2));
				rx_left = $urandom_range(50, 400);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:   rsp_ch.ready <= 1'b1;
				RX_CHOPPY: rsp_ch.ready <= 1'($urandom_range(1));
				default:   rsp_ch.ready <= ($urandom_range(11) == 0);
			endcase
		end
	end

	initial begin
		plan_row_t row;
		int sent, phase_len, burst_left, roll;
		logic gaps_on, kind;
		udata_t hi, lo, phase_dt, dt;
		sdata_t phase_target, meas_now, tgt, meas, pull, jitter;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PROP_GAIN;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_COMPUTE;
		req_ch.target = '0;
		req_ch.measured = '0;
		req_ch.step_time = '0;
		pin_on = 1'b0;
		pin_drive = '0;
		kp_q = 0;
		ki_q = 0;
		kd_q = 0;
		lim_hi = longint'(LIMIT_HIGH_RST);
		lim_lo = longint'(LIMIT_LOW_RST);
		run_on = 1'b1;
		integ_q = 0;
		err_hist = 0;
		held_drive = 0;
		smooth_q = 0;
		n_fail = 0;
		n_checked = 0;
		n_writes = 0;
		n_compute = 0;
		n_clear = 0;
		n_held = 0;
		n_zero_dt = 0;
		cycle_count = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		for (int i = 0; i < PLAN_LEN; i++) begin
			row = PLAN[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.index, row.value);
			end else begin
				send_item(row.req_type, row.target, row.measured, row.step_time,
					row.kind == ROW_CHECK, row.value);
			end
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			write_reg(CFG_PROP_GAIN, pick_gain());
			write_reg(CFG_INTEG_GAIN, pick_gain());
			write_reg(CFG_DERIV_GAIN, pick_gain());
			case ($urandom_range(7))
				0: begin
					hi = Q_MAX;
					lo = Q_MIN;
				end
				1: begin
					hi = $urandom();
					lo = $urandom();
				end
				2: begin
					hi = -udata_t'($urandom_range(0, 32'h00100000));
					lo = $urandom_range(0, 32'h00100000);
				end
				default: begin
					hi = $urandom_range(32'h00008000, 32'h04000000);
					lo = -udata_t'($urandom_range(32'h00008000, 32'h04000000));
				end
			endcase
			write_reg(CFG_LIMIT_HIGH, hi);
			write_reg(CFG_LIMIT_LOW, lo);
			if ($urandom_range(9) == 0) begin
				write_reg($urandom_range(1) ? CFG_BAD_HI : CFG_BAD_LO, $urandom());
			end
			// upper data bits are don't-care for the enable
			write_reg(CFG_RUN_ENABLE, ($urandom() & ~32'h1) | udata_t'($urandom_range(7) != 0));

			phase_len = $urandom_range(15, 60);
			gaps_on = ($urandom_range(3) != 0);
			burst_left = $urandom_range(1, 16);
			phase_target = $signed(udata_t'($urandom_range(0, 32'h00800000)) - 32'h00400000);
			meas_now = $signed(udata_t'($urandom_range(0, 32'h00800000)) - 32'h00400000);
			case ($urandom_range(9))
				0: phase_dt = 32'h0;
				1: phase_dt = pick_word();
				default: phase_dt = $urandom_range(32'h00004000, DT_ONE);
			endcase

			for (int k = 0; k < phase_len; k++) begin
				roll = $urandom_range(99);
				kind = REQ_COMPUTE;
				if (roll < 6) begin
					kind = REQ_CLEAR;
					tgt = $urandom();
					meas = $urandom();
					dt = $urandom();
				end else if (roll < 76) begin
					// plant follows the setpoint with some noise
					pull = (phase_target - meas_now) >>> 3;
					jitter = $signed(udata_t'($urandom_range(0, 32'h2000)) - 32'h1000);
					meas_now = meas_now + pull + jitter;
					tgt = phase_target;
					meas = meas_now;
					dt = (phase_dt == 0) ? phase_dt : phase_dt + $urandom_range(0, 15);
				end else begin
					tgt = pick_word();
					meas = pick_word();
					dt = pick_word();
				end
				send_item(kind, tgt, meas, dt, 1'b0, '0);
				sent++;
				if ($urandom_range(39) == 0) begin
					settle();
				end else if (gaps_on && burst_left == 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 40)) @(posedge clk);
					burst_left = $urandom_range(1, 16);
				end else if (burst_left != 0) begin
					burst_left--;
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (drive_expect_q.size() != 0) begin
			report_mismatch($sformatf("%0d drives never arrived", drive_expect_q.size()));
		end

		$display("covered %0d computes and %0d clears; %0d held while disabled, %0d at zero step",
			n_compute, n_clear, n_held, n_zero_dt);
		$display("compared %0d drive values across %0d register writes", n_checked, n_writes);
		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
